// ===== src/pbi_pkg.sv =====
// Shared types and constants for the ping-pong block interleaver.
// Used by the interleaver top level and its port checker; no dependencies.
`default_nettype none

package pbi_pkg;

  // Array geometry and word width.
  localparam int MAX_ROWS    = 32;
  localparam int MAX_COLUMNS = 32;
  localparam int DATA_WIDTH  = 32;

  localparam int BANK_WORDS  = MAX_ROWS * MAX_COLUMNS;

  localparam int ROW_IDX_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_IDX_W   = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int ROWS_W      = $clog2(MAX_ROWS + 1);
  localparam int COLS_W      = $clog2(MAX_COLUMNS + 1);
  localparam int ADDR_W      = (BANK_WORDS > 1) ? $clog2(BANK_WORDS) : 1;
  localparam int SIZE_W      = $clog2(BANK_WORDS + 1);

  // Configuration port.
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 6;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMNS = 1'b1;
  localparam logic [CFG_DATA_W-1:0] ROWS_RESET    = 6'd8;
  localparam logic [CFG_DATA_W-1:0] COLUMNS_RESET = 6'd8;

  // Action codes of an input word.
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_READ  = 1'b1;

  typedef struct packed {
    logic        action;
    logic [31:0] sample;
  } in_word_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        ready_res;
  } out_word_t;

endpackage

`default_nettype wire

// ===== src/ping_pong_block_interleaver.sv =====
// Ping-pong block interleaver: column-wise writes, row-wise reads, two banks in one RAM.
// Depends on pbi_pkg for geometry constants, register codes and word types.
//
//   channel | direction | handshake               | payload
//   in      | input     | in_valid_i / in_stall_o  | in_word_i  (action, sample)
//   out     | output    | out_valid_o / out_stall_i| out_word_o (read_data, ready_res)
//   cfg     | input     | cfg_we_i                | cfg_index_i, cfg_data_i
//
// One word is accepted per clock while in_stall_o is low; the sample RAM's registered
// read port gives its result in the next cycle. in_stall_o is high only while a finished
// result is held under out_stall_i. Reset clears positions, banks and the ready flag
// and loads rows and columns with 8; the sample RAM is not cleared.
`default_nettype none

module ping_pong_block_interleaver (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output      logic                            in_stall_o,
  input  wire pbi_pkg::in_word_t               in_word_i,
  output      logic                            out_valid_o,
  input  wire logic                            out_stall_i,
  output      pbi_pkg::out_word_t              out_word_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [pbi_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [pbi_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import pbi_pkg::*;

  logic [CFG_DATA_W-1:0] rows_q, columns_q;
  logic [ROWS_W-1:0]     r_eff;
  logic [COLS_W-1:0]     c_eff;
  logic [SIZE_W-1:0]     size;
  logic [SIZE_W-1:0]     threshold;

  logic                  wbank_q, wbank_d;
  logic [ROW_IDX_W-1:0]  wrow_q, wrow_d, wrow_use;
  logic [COL_IDX_W-1:0]  wcol_q, wcol_d, wcol_use;
  logic [ROWS_W-1:0]     wrow_inc;
  logic [COLS_W-1:0]     wcol_inc;
  logic                  rbank_q, rbank_d;
  logic [ADDR_W-1:0]     ridx_q, ridx_d, ridx_use;
  logic [SIZE_W-1:0]     ridx_inc;
  logic                  ready_q, ready_d;
  logic [SIZE_W-1:0]     written;

  logic                  accept, is_read;
  logic [ADDR_W-1:0]     waddr;

  logic [DATA_WIDTH-1:0] mem [2*BANK_WORDS];
  logic [DATA_WIDTH-1:0] rdata_q;
  logic                  out_valid_q, out_read_q, out_ready_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q    <= ROWS_RESET;
      columns_q <= COLUMNS_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_ROWS:    rows_q    <= cfg_data_i;
        REG_COLUMNS: columns_q <= cfg_data_i;
        default:     ;
      endcase
    end
  end

  // Out-of-range sizes act as the nearest legal size.
  always_comb begin
    if (rows_q == '0) begin
      r_eff = ROWS_W'(1);
    end else if (int'(rows_q) > MAX_ROWS) begin
      r_eff = ROWS_W'(MAX_ROWS);
    end else begin
      r_eff = ROWS_W'(rows_q);
    end
    if (columns_q == '0) begin
      c_eff = COLS_W'(1);
    end else if (int'(columns_q) > MAX_COLUMNS) begin
      c_eff = COLS_W'(MAX_COLUMNS);
    end else begin
      c_eff = COLS_W'(columns_q);
    end
  end

  // The ready threshold rows*columns - rows - columns + 1 equals (rows-1)*(columns-1).
  assign size      = SIZE_W'(r_eff) * SIZE_W'(c_eff);
  assign threshold = SIZE_W'(r_eff - ROWS_W'(1)) * SIZE_W'(c_eff - COLS_W'(1));

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign is_read    = (in_word_i.action == ACT_READ);

  // Write position: down the column first, then the next column, then the other bank.
  always_comb begin
    wrow_use = (ROWS_W'(wrow_q) < r_eff) ? wrow_q : '0;
    wcol_use = (COLS_W'(wcol_q) < c_eff) ? wcol_q : '0;
    wrow_inc = ROWS_W'(wrow_q) + ROWS_W'(1);
    wcol_inc = COLS_W'(wcol_q) + COLS_W'(1);
    wrow_d   = wrow_q;
    wcol_d   = wcol_q;
    wbank_d  = wbank_q;
    if (accept && !is_read) begin
      if (wrow_inc >= r_eff) begin
        wrow_d = '0;
        if (wcol_inc >= c_eff) begin
          wcol_d  = '0;
          wbank_d = ~wbank_q;
        end else begin
          wcol_d = wcol_inc[COL_IDX_W-1:0];
        end
      end else begin
        wrow_d = wrow_inc[ROW_IDX_W-1:0];
      end
    end
  end

  assign waddr = ADDR_W'(SIZE_W'(wrow_use) * SIZE_W'(c_eff) + SIZE_W'(wcol_use));

  // Read position walks the bank linearly, which is row by row.
  always_comb begin
    ridx_use = (SIZE_W'(ridx_q) < size) ? ridx_q : '0;
    ridx_inc = SIZE_W'(ridx_q) + SIZE_W'(1);
    ridx_d   = ridx_q;
    rbank_d  = rbank_q;
    if (accept && is_read) begin
      if (ridx_inc >= size) begin
        ridx_d  = '0;
        rbank_d = ~rbank_q;
      end else begin
        ridx_d = ridx_inc[ADDR_W-1:0];
      end
    end
  end

  // The flag looks at the write position as it stands after this word.
  assign written = SIZE_W'(wcol_d) * SIZE_W'(r_eff) + SIZE_W'(wrow_d);
  assign ready_d = ready_q || (accept && (written > threshold));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wbank_q <= 1'b0;
      wrow_q  <= '0;
      wcol_q  <= '0;
      rbank_q <= 1'b0;
      ridx_q  <= '0;
      ready_q <= 1'b0;
    end else begin
      wbank_q <= wbank_d;
      wrow_q  <= wrow_d;
      wcol_q  <= wcol_d;
      rbank_q <= rbank_d;
      ridx_q  <= ridx_d;
      ready_q <= ready_d;
    end
  end

  // Sample RAM: one write or one registered read per cycle when a word is accepted.
  // A read never shares a cycle with a write, so it always sees the stored word.
  always_ff @(posedge clk_i) begin
    if (accept && !is_read) begin
      mem[{wbank_q, waddr}] <= DATA_WIDTH'(in_word_i.sample);
    end
    if (accept && is_read) begin
      rdata_q <= mem[{rbank_q, ridx_use}];
    end
  end

  // Output register; the RAM data register above doubles as its payload.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_read_q  <= 1'b0;
      out_ready_q <= 1'b0;
    end else begin
      if (accept) begin
        out_valid_q <= 1'b1;
        out_read_q  <= is_read;
        out_ready_q <= ready_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o          = out_valid_q;
  assign out_word_o.read_data = out_read_q ? 32'(rdata_q) : '0;
  assign out_word_o.ready_res = out_ready_q;

endmodule

`default_nettype wire

// ===== src/pbi_checker.sv =====
// Port-level checker for the ping-pong block interleaver, bound to its top level.
// Depends on pbi_pkg for the word types.
`default_nettype none

module pbi_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_stall_o,
  input wire pbi_pkg::in_word_t  in_word_i,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire pbi_pkg::out_word_t out_word_o
);
  import pbi_pkg::*;

  // A stalled input word stays offered and does not change.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_word_i))
    else $error("stalled input word changed");

  // A stalled result word does not change.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("stalled output word changed");

  // The input side is held back only by a finished word waiting at the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a pending output word");

  // Every accepted word yields a result in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("accepted word produced no result");

  // Once a delivered word shows the ready flag, every later word shows it too.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && out_word_o.ready_res
      |=> !out_valid_o || out_word_o.ready_res)
    else $error("ready flag dropped");

endmodule

bind ping_pong_block_interleaver pbi_checker u_pbi_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_word_i   (in_word_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);

`default_nettype wire

// ===== tb/tb_ping_pong_block_interleaver.sv =====
// Self-checking testbench for the ping-pong block interleaver: column-wise writes,
// row-wise reads, sticky ready flag, under random idle and stall on both channels.
// Depends on pbi_pkg for the word types, register indexes and action codes.
module tb_ping_pong_block_interleaver;
  timeunit 1ns;
  timeprecision 1ps;

  import pbi_pkg::*;

  // Write and read positions of the two banks, as the block tracks them.
  typedef struct {
    bit wbank;
    int wrow;
    int wcol;
    bit rbank;
    int ridx;
    bit ready;
  } ilv_pos_t;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  in_word_t              in_word_i   = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  out_word_t             out_word_o;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = REG_ROWS;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  ping_pong_block_interleaver u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Register copies, shared by stimulus generation and prediction; both only
  // change while the block is idle.
  logic [CFG_DATA_W-1:0] cfg_rows = ROWS_RESET;
  logic [CFG_DATA_W-1:0] cfg_cols = COLUMNS_RESET;

  in_word_t  pending_words[$];
  out_word_t predicted_words[$];
  logic [DATA_WIDTH-1:0] mirror_ram [0:2*BANK_WORDS-1];
  bit        gen_filled [0:2*BANK_WORDS-1];
  ilv_pos_t  gen_pos  = '{default: 0};
  ilv_pos_t  chk_pos  = '{default: 0};
  int        queued_count  = 0;
  int        checked_count = 0;
  int        mismatches    = 0;
  bit        calm          = 1'b0;

  function automatic int eff_dim(input logic [CFG_DATA_W-1:0] v, input int limit);
    if (v == 0) return 1;
    if (v > limit) return limit;
    return v;
  endfunction

  // Returns the RAM address that the word touches and moves the positions on.
  function automatic int advance_position(inout ilv_pos_t p, input logic act,
                                          input logic [CFG_DATA_W-1:0] rows_reg,
                                          input logic [CFG_DATA_W-1:0] cols_reg);
    int r, c, blk_size, row, col, addr;
    r = eff_dim(rows_reg, MAX_ROWS);
    c = eff_dim(cols_reg, MAX_COLUMNS);
    blk_size = r * c;
    if (act == ACT_WRITE) begin
      // A position left beyond a shrunken size restarts at zero.
      row  = (p.wrow < r) ? p.wrow : 0;
      col  = (p.wcol < c) ? p.wcol : 0;
      addr = (p.wbank ? BANK_WORDS : 0) + (row * c + col) % BANK_WORDS;
      p.wrow++;
      if (p.wrow >= r) begin
        p.wrow = 0;
        p.wcol++;
        if (p.wcol >= c) begin
          p.wcol  = 0;
          p.wbank = ~p.wbank;
        end
      end
    end else begin
      addr = (p.rbank ? BANK_WORDS : 0) + ((p.ridx < blk_size) ? p.ridx : 0) % BANK_WORDS;
      p.ridx++;
      if (p.ridx >= blk_size) begin
        p.ridx  = 0;
        p.rbank = ~p.rbank;
      end
    end
    if (!p.ready && (p.wcol * r + p.wrow > blk_size - r - c + 1)) p.ready = 1'b1;
    return addr;
  endfunction

  function automatic logic [31:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_dim();
    case ($urandom_range(0, 9))
      6:       return 6'd32;
      7:       return CFG_DATA_W'($urandom_range(7, 31));
      8:       return 6'd0;
      9:       return CFG_DATA_W'($urandom_range(33, 63));
      default: return CFG_DATA_W'($urandom_range(1, 6));
    endcase
  endfunction

  // Queues one word. A read that would hit a never-written RAM word is turned
  // into a write, so the stimulus never reads undefined contents.
  task automatic add_item(input logic act, input logic [31:0] sample);
    ilv_pos_t probe;
    int       addr;
    in_word_t w;
    probe = gen_pos;
    addr  = advance_position(probe, act, cfg_rows, cfg_cols);
    if (act == ACT_READ && !gen_filled[addr]) begin
      act   = ACT_WRITE;
      probe = gen_pos;
      addr  = advance_position(probe, act, cfg_rows, cfg_cols);
    end
    if (act == ACT_WRITE) gen_filled[addr] = 1'b1;
    gen_pos  = probe;
    w.action = act;
    w.sample = sample;
    pending_words.push_back(w);
    queued_count++;
  endtask

  task automatic drain();
    while (checked_count != queued_count || in_valid_i || pending_words.size() != 0)
      @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_ROWS) cfg_rows = val;
    else cfg_cols = val;
  endtask

  task automatic set_size(input logic [CFG_DATA_W-1:0] r, input logic [CFG_DATA_W-1:0] c);
    drain();
    write_reg(REG_ROWS, r);
    write_reg(REG_COLUMNS, c);
  endtask

  // Input side: hold each word until taken, then idle for a drawn number of cycles.
  int in_gap = 0;
  always @(posedge clk_i) begin
    int       addr;
    out_word_t exp;
    if (in_valid_i && !in_stall_o) begin
      addr = advance_position(chk_pos, in_word_i.action, cfg_rows, cfg_cols);
      if (in_word_i.action == ACT_WRITE) begin
        mirror_ram[addr] = in_word_i.sample;
        exp.read_data    = '0;
      end else begin
        exp.read_data = mirror_ram[addr];
      end
      exp.ready_res = chk_pos.ready;
      predicted_words.push_back(exp);
    end
    if (!(in_valid_i && in_stall_o)) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid_i <= 1'b0;
      end else if (pending_words.size() != 0) begin
        in_word_i  <= pending_words.pop_front();
        in_valid_i <= 1'b1;
        in_gap = calm ? 0 : $urandom_range(0, 14);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Output side: compare each taken word with the oldest prediction, then stall.
  int out_hold = 0;
  always @(posedge clk_i) begin
    out_word_t exp;
    if (out_valid_o && !out_stall_i) begin
      if (predicted_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: read_data %h ready_res %b",
                   out_word_o.read_data, out_word_o.ready_res);
      end else begin
        exp = predicted_words.pop_front();
        if (exp.read_data !== out_word_o.read_data || exp.ready_res !== out_word_o.ready_res) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch on word %0d: expected read_data %h ready_res %b, got %h %b",
                     checked_count, exp.read_data, exp.ready_res,
                     out_word_o.read_data, out_word_o.ready_res);
        end
      end
      checked_count++;
      out_hold = calm ? 0 : $urandom_range(0, 14);
    end
    if (out_hold > 0) begin
      out_hold--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  initial begin
    int base, n, blk_size, nblk, nread;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // A 1x1 block: every word swaps its own bank and the ready flag never sets.
    set_size(6'd1, 6'd1);
    add_item(ACT_WRITE, 32'h0000_0000);
    add_item(ACT_READ, 32'h0000_0000);
    add_item(ACT_WRITE, 32'hFFFF_FFFF);
    add_item(ACT_WRITE, 32'h8000_0001);
    add_item(ACT_READ, 32'hFFFF_FFFF);
    add_item(ACT_READ, 32'h0000_0000);
    add_item(ACT_READ, 32'h0000_0000);

    // Zero sizes act as one.
    set_size(6'd0, 6'd0);
    add_item(ACT_WRITE, 32'h5A5A_5A5A);
    add_item(ACT_READ, 32'h0000_0000);
    add_item(ACT_READ, 32'h0000_0000);

    // A read before the flag is up still proceeds; the flag sets on the third write.
    set_size(6'd2, 6'd3);
    add_item(ACT_READ, 32'h0000_0000);
    add_item(ACT_WRITE, 32'h0000_0000);
    add_item(ACT_WRITE, 32'hFFFF_FFFF);
    add_item(ACT_WRITE, 32'h0000_0001);
    add_item(ACT_WRITE, 32'h8000_0000);
    add_item(ACT_WRITE, 32'h7FFF_FFFF);
    add_item(ACT_WRITE, 32'hFFFF_FFFE);
    repeat (6) add_item(ACT_READ, 32'h0000_0000);

    // Sizes above the array clamp to its maximum.
    set_size(6'd63, 6'd40);
    repeat (3) add_item(ACT_WRITE, pick_sample());
    repeat (2) add_item(ACT_READ, pick_sample());

    base = queued_count;
    while (queued_count - base < 650) begin
      set_size(pick_dim(), pick_dim());
      calm     = ($urandom_range(0, 3) == 0);
      blk_size = eff_dim(cfg_rows, MAX_ROWS) * eff_dim(cfg_cols, MAX_COLUMNS);
      n        = $urandom_range(20, 60);
      if (blk_size <= 64 && $urandom_range(0, 9) < 7) begin
        // Whole blocks: fill one, then read it out; now and then cut the read short.
        nblk = (n / (2 * blk_size) > 0) ? n / (2 * blk_size) : 1;
        repeat (nblk) begin
          repeat (blk_size) add_item(ACT_WRITE, pick_sample());
          nread = ($urandom_range(0, 4) == 0) ? $urandom_range(0, blk_size) : blk_size;
          repeat (nread) add_item(ACT_READ, pick_sample());
        end
      end else begin
        repeat (n) add_item($urandom_range(0, 1) ? ACT_READ : ACT_WRITE, pick_sample());
      end
    end

    drain();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && predicted_words.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
